### hdl/x86enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86enc_pkg
// Shared types and constants for the x86-64 instruction encoder.
// ----------------------------------------------------------------------------
package x86enc_pkg;

  // Longest instruction form in bytes, length field width, and queue depth
  localparam int unsigned MAX_BYTES       = 10;
  localparam int unsigned LEN_W           = 4;
  localparam int unsigned IEC_QUEUE_DEPTH = 2;

  typedef enum logic [4:0] {
    OP_MOV_IMM64    = 5'd0,
    OP_MOV_IMM32    = 5'd1,
    OP_MOV_REG_REG  = 5'd2,
    OP_LOAD         = 5'd3,
    OP_STORE        = 5'd4,
    OP_ADD_RR       = 5'd5,
    OP_ADD_IMM32    = 5'd6,
    OP_SUB_RR       = 5'd7,
    OP_SUB_IMM32    = 5'd8,
    OP_IMUL_RR      = 5'd9,
    OP_XOR_RR       = 5'd10,
    OP_CMP_RR       = 5'd11,
    OP_CMP_IMM32    = 5'd12,
    OP_TEST_RR      = 5'd13,
    OP_LEA          = 5'd14,
    OP_SHL_IMM8     = 5'd15,
    OP_SHR_IMM8     = 5'd16,
    OP_SAR_IMM8     = 5'd17,
    OP_NEG          = 5'd18,
    OP_CQO          = 5'd19,
    OP_IDIV         = 5'd20,
    OP_RET          = 5'd21,
    OP_JMP_REL32    = 5'd22,
    OP_JCC_REL32    = 5'd23,
    OP_CALL_REL32   = 5'd24,
    OP_CALL_REG     = 5'd25,
    OP_PUSH         = 5'd26,
    OP_POP          = 5'd27,
    OP_SUB_RSP_IMM8 = 5'd28,
    OP_ADD_RSP_IMM8 = 5'd29
  } op_t;

  // Encoding shape chosen by the classifier
  typedef enum logic [2:0] {
    FORM_NONE,
    FORM_REG,
    FORM_IMUL,
    FORM_MEM,
    FORM_RAW
  } form_t;

  // One encoded instruction: byte k sits at bits [8k+7:8k]
  typedef struct packed {
    logic [8*MAX_BYTES-1:0] bytes;
    logic [LEN_W-1:0]       len;
  } entry_t;

  localparam logic [7:0] BYTE_REX_W   = 8'h48;
  localparam logic [7:0] BYTE_REX_B   = 8'h41;
  localparam logic [7:0] BYTE_MOV_I   = 8'hC7;
  localparam logic [7:0] BYTE_MOV_LD  = 8'h8B;
  localparam logic [7:0] BYTE_MOV_ST  = 8'h89;
  localparam logic [7:0] BYTE_LEA     = 8'h8D;
  localparam logic [7:0] BYTE_ALU_I   = 8'h81;
  localparam logic [7:0] BYTE_SHIFT_I = 8'hC1;
  localparam logic [7:0] BYTE_GRP3    = 8'hF7;
  localparam logic [7:0] BYTE_ESC     = 8'h0F;
  localparam logic [7:0] BYTE_IMUL    = 8'hAF;
  localparam logic [7:0] BYTE_JMP     = 8'hE9;
  localparam logic [7:0] BYTE_MOV_RI  = 8'hB8;
  localparam logic [7:0] BYTE_ADD     = 8'h01;
  localparam logic [7:0] BYTE_SUB     = 8'h29;
  localparam logic [7:0] BYTE_XOR     = 8'h31;
  localparam logic [7:0] BYTE_CMP     = 8'h39;
  localparam logic [7:0] BYTE_TEST    = 8'h85;
  localparam logic [7:0] BYTE_CQO     = 8'h99;
  localparam logic [7:0] BYTE_RET     = 8'hC3;
  localparam logic [7:0] BYTE_JCC     = 8'h80;
  localparam logic [7:0] BYTE_CALL    = 8'hE8;
  localparam logic [7:0] BYTE_GRP5    = 8'hFF;
  localparam logic [7:0] BYTE_PUSH    = 8'h50;
  localparam logic [7:0] BYTE_POP     = 8'h58;
  localparam logic [7:0] BYTE_ALU_I8  = 8'h83;
  localparam logic [7:0] BYTE_RSP_SUB = 8'hEC;
  localparam logic [7:0] BYTE_RSP_ADD = 8'hC4;
  localparam logic [7:0] BYTE_SIB_RSP = 8'h24;

endpackage

### hdl/x86enc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86enc_front
// Classifies one request and assembles its full byte string and length.
// ----------------------------------------------------------------------------
module x86enc_front
  import x86enc_pkg::*;
(
  input  logic [4:0]  operation,
  input  logic [3:0]  first_reg,
  input  logic [3:0]  second_reg,
  input  logic [63:0] immediate,
  input  logic [31:0] displacement,
  input  logic [7:0]  small_count,
  input  logic [3:0]  cond_code,
  output entry_t      entry,
  output logic        entry_ok
);

  form_t       form;
  logic [7:0]  opc;
  logic [3:0]  rf;
  logic [3:0]  mf;
  logic [31:0] tail;
  logic [3:0]  tail_len;
  logic [79:0] raw;
  logic [3:0]  raw_len;

  logic [7:0]  rex;
  logic [7:0]  modrm_reg;
  logic [7:0]  modrm_mem;
  logic [1:0]  mode;
  logic        sib;
  logic [31:0] dsp;
  logic [3:0]  dsp_len;
  logic [39:0] after3;
  logic        disp8_ok;

  // Classification: which shape, which opcode, which register fields
  always_comb begin
    form     = FORM_NONE;
    opc      = '0;
    rf       = '0;
    mf       = first_reg;
    tail     = '0;
    tail_len = '0;
    raw      = '0;
    raw_len  = '0;
    unique case (op_t'(operation))
      OP_MOV_IMM64: begin
        form    = FORM_RAW;
        raw     = {immediate, BYTE_MOV_RI + {5'd0, first_reg[2:0]},
                   BYTE_REX_W | {7'd0, first_reg[3]}};
        raw_len = 4'd10;
      end
      OP_MOV_IMM32: begin
        form = FORM_REG; opc = BYTE_MOV_I; tail = immediate[31:0]; tail_len = 4'd4;
      end
      OP_MOV_REG_REG: begin form = FORM_REG; opc = BYTE_MOV_ST; rf = second_reg; end
      OP_LOAD: begin
        form = FORM_MEM; opc = BYTE_MOV_LD; rf = first_reg; mf = second_reg;
      end
      OP_STORE: begin
        form = FORM_MEM; opc = BYTE_MOV_ST; rf = first_reg; mf = second_reg;
      end
      OP_ADD_RR: begin form = FORM_REG; opc = BYTE_ADD; rf = second_reg; end
      OP_ADD_IMM32: begin
        form = FORM_REG; opc = BYTE_ALU_I; tail = immediate[31:0]; tail_len = 4'd4;
      end
      OP_SUB_RR: begin form = FORM_REG; opc = BYTE_SUB; rf = second_reg; end
      OP_SUB_IMM32: begin
        form = FORM_REG; opc = BYTE_ALU_I; rf = 4'd5;
        tail = immediate[31:0]; tail_len = 4'd4;
      end
      OP_IMUL_RR: begin form = FORM_IMUL; rf = first_reg; mf = second_reg; end
      OP_XOR_RR: begin form = FORM_REG; opc = BYTE_XOR; rf = second_reg; end
      OP_CMP_RR: begin form = FORM_REG; opc = BYTE_CMP; rf = second_reg; end
      OP_CMP_IMM32: begin
        form = FORM_REG; opc = BYTE_ALU_I; rf = 4'd7;
        tail = immediate[31:0]; tail_len = 4'd4;
      end
      OP_TEST_RR: begin form = FORM_REG; opc = BYTE_TEST; rf = second_reg; end
      OP_LEA: begin
        form = FORM_MEM; opc = BYTE_LEA; rf = first_reg; mf = second_reg;
      end
      OP_SHL_IMM8: begin
        form = FORM_REG; opc = BYTE_SHIFT_I; rf = 4'd4;
        tail = {24'd0, small_count}; tail_len = 4'd1;
      end
      OP_SHR_IMM8: begin
        form = FORM_REG; opc = BYTE_SHIFT_I; rf = 4'd5;
        tail = {24'd0, small_count}; tail_len = 4'd1;
      end
      OP_SAR_IMM8: begin
        form = FORM_REG; opc = BYTE_SHIFT_I; rf = 4'd7;
        tail = {24'd0, small_count}; tail_len = 4'd1;
      end
      OP_NEG: begin form = FORM_REG; opc = BYTE_GRP3; rf = 4'd3; end
      OP_CQO: begin
        form = FORM_RAW; raw = {64'd0, BYTE_CQO, BYTE_REX_W}; raw_len = 4'd2;
      end
      OP_IDIV: begin form = FORM_REG; opc = BYTE_GRP3; rf = 4'd7; end
      OP_RET: begin form = FORM_RAW; raw = {72'd0, BYTE_RET}; raw_len = 4'd1; end
      OP_JMP_REL32: begin
        form = FORM_RAW; raw = {72'd0, BYTE_JMP}; raw_len = 4'd5;
      end
      OP_JCC_REL32: begin
        form    = FORM_RAW;
        raw     = {64'd0, BYTE_JCC | {4'd0, cond_code}, BYTE_ESC};
        raw_len = 4'd6;
      end
      OP_CALL_REL32: begin
        form = FORM_RAW; raw = {72'd0, BYTE_CALL}; raw_len = 4'd5;
      end
      OP_CALL_REG: begin form = FORM_REG; opc = BYTE_GRP5; rf = 4'd2; end
      OP_PUSH, OP_POP: begin
        form = FORM_RAW;
        opc  = (op_t'(operation) == OP_PUSH) ? BYTE_PUSH : BYTE_POP;
        if (first_reg[3]) begin
          raw     = {64'd0, opc + {5'd0, first_reg[2:0]}, BYTE_REX_B};
          raw_len = 4'd2;
        end else begin
          raw     = {72'd0, opc + {5'd0, first_reg[2:0]}};
          raw_len = 4'd1;
        end
      end
      OP_SUB_RSP_IMM8: begin
        form    = FORM_RAW;
        raw     = {48'd0, small_count, BYTE_RSP_SUB, BYTE_ALU_I8, BYTE_REX_W};
        raw_len = 4'd4;
      end
      OP_ADD_RSP_IMM8: begin
        form    = FORM_RAW;
        raw     = {48'd0, small_count, BYTE_RSP_ADD, BYTE_ALU_I8, BYTE_REX_W};
        raw_len = 4'd4;
      end
      default: form = FORM_NONE;
    endcase
  end

  // Memory addressing: mod from displacement, rbp/r13 base never takes mod 0
  assign disp8_ok  = (displacement[31:7] == '0) || (displacement[31:7] == '1);
  assign sib       = (mf[2:0] == 3'd4);

  always_comb begin
    if ((displacement == '0) && (mf[2:0] != 3'd5)) begin
      mode    = 2'd0;
      dsp     = '0;
      dsp_len = 4'd0;
    end else if (disp8_ok) begin
      mode    = 2'd1;
      dsp     = {24'd0, displacement[7:0]};
      dsp_len = 4'd1;
    end else begin
      mode    = 2'd2;
      dsp     = displacement;
      dsp_len = 4'd4;
    end
    after3 = sib ? {dsp, BYTE_SIB_RSP} : {8'd0, dsp};
  end

  assign rex       = {4'h4, 1'b1, rf[3], 1'b0, mf[3]};
  assign modrm_reg = {2'b11, rf[2:0], mf[2:0]};
  assign modrm_mem = {mode, rf[2:0], mf[2:0]};

  // Assembly
  always_comb begin
    unique case (form)
      FORM_REG: begin
        entry.bytes = {24'd0, tail, modrm_reg, opc, rex};
        entry.len   = 4'd3 + tail_len;
      end
      FORM_IMUL: begin
        entry.bytes = {48'd0, modrm_reg, BYTE_IMUL, BYTE_ESC, rex};
        entry.len   = 4'd4;
      end
      FORM_MEM: begin
        entry.bytes = {16'd0, after3, modrm_mem, opc, rex};
        entry.len   = 4'd3 + {3'd0, sib} + dsp_len;
      end
      FORM_RAW: begin
        entry.bytes = raw;
        entry.len   = raw_len;
      end
      default: begin
        entry.bytes = '0;
        entry.len   = '0;
      end
    endcase
  end

  assign entry_ok = (entry.len != '0);

endmodule

### hdl/x86enc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86enc_queue
// Short FIFO of encoded instructions between the front and back parts.
// ----------------------------------------------------------------------------
module x86enc_queue
  import x86enc_pkg::*;
#(
  parameter int unsigned DEPTH = IEC_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/x86enc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86enc_back
// Serializes one queued instruction a byte per transaction.
// ----------------------------------------------------------------------------
module x86enc_back
  import x86enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  entry_t     q_data,
  input  logic       q_empty,
  output logic       q_rd,
  output logic [7:0] code_byte,
  output logic       last_byte,
  output logic       empty,
  input  logic       pop
);

  logic                   cur_valid;
  logic [8*MAX_BYTES-1:0] cur_bytes;
  logic [LEN_W-1:0]       remain;
  logic                   take;

  // Load a new entry when idle or when the final byte leaves
  assign take      = !cur_valid || (pop && (remain == LEN_W'(1)));
  assign q_rd      = take && !q_empty;
  assign code_byte = cur_bytes[7:0];
  assign last_byte = (remain == LEN_W'(1));
  assign empty     = !cur_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      remain    <= '0;
    end else if (take) begin
      cur_valid <= !q_empty;
      remain    <= q_empty ? '0 : q_data.len;
    end else if (pop) begin
      remain    <= remain - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_bytes <= q_data.bytes;
    end else if (pop && cur_valid) begin
      cur_bytes <= cur_bytes >> 8;
    end
  end

endmodule

### hdl/x86_64_instruction_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder_unit
// Encodes one instruction request per transaction into x86-64 machine code.
// ----------------------------------------------------------------------------
// Input channel: present a request on operation/first_reg/second_reg/
// immediate/displacement/small_count/cond_code with push high; it is taken
// on a clock edge where full is low. Requests with an unused operation code
// are taken and produce no bytes.
// Output channel: while empty is low, code_byte holds the next machine code
// byte and last_byte marks the final byte of its instruction; each edge with
// pop high moves one byte.
// When the block is idle, a taken request is written into the queue and
// then loaded into the back part's output register, where its first byte
// shows. The output moves one byte per cycle while pop is high, so an
// instruction of L bytes (1 to 10) leaves in L pops, and one-byte requests
// can stream every cycle. The back part's byte serializer sets that rate.
// A stalled receiver freezes the current byte; the front keeps accepting
// requests until the QUEUE_DEPTH-entry queue fills, then raises full.
// Reset (rst, synchronous) drops everything queued and in flight.
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder_unit
  import x86enc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = IEC_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [4:0]  operation,
  input  logic [3:0]  first_reg,
  input  logic [3:0]  second_reg,
  input  logic [63:0] immediate,
  input  logic [31:0] displacement,
  input  logic [7:0]  small_count,
  input  logic [3:0]  cond_code,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  code_byte,
  output logic        last_byte
);

  entry_t enc_entry;
  logic   enc_ok;
  logic   q_wr;
  entry_t q_data;
  logic   q_empty;
  logic   q_rd;

  // Front: decode and assemble the whole byte string in one pass
  x86enc_front u_front (
    .operation    (operation),
    .first_reg    (first_reg),
    .second_reg   (second_reg),
    .immediate    (immediate),
    .displacement (displacement),
    .small_count  (small_count),
    .cond_code    (cond_code),
    .entry        (enc_entry),
    .entry_ok     (enc_ok)
  );

  // Only requests that emit bytes take a queue slot
  assign q_wr = push && !full && enc_ok;

  x86enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (enc_entry),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Back: output register holding the current instruction, shifted per byte
  x86enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .code_byte (code_byte),
    .last_byte (last_byte),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

### hdl/x86enc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86enc_checker
// Port-level checks on the encoder's queue-style channels.
// ----------------------------------------------------------------------------
module x86enc_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] code_byte,
  input logic       last_byte
);

  // A byte that is not taken stays put
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(code_byte) && $stable(last_byte)))
    else $error("output byte changed while stalled");

  // Reset leaves nothing to read
  assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // A full queue implies the serializer holds an instruction
  assert property (@(posedge clk) disable iff (rst) full |-> !empty)
    else $error("queue full while serializer idle");

  // An instruction never ends before its marked last byte
  assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_byte) |=> !empty)
    else $error("instruction cut short");

endmodule

bind x86_64_instruction_encoder_unit x86enc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .code_byte (code_byte),
  .last_byte (last_byte)
);

### tb/tb_x86_64_instruction_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x86_64_instruction_encoder_unit
// Self-checking bench for the x86-64 instruction encoder.
// ----------------------------------------------------------------------------
// Every accepted instruction request is encoded by a local predictor into
// its expected byte stream. The stream is queued, and each byte popped from
// the encoder is checked against the oldest queued byte, value and
// end-of-instruction flag both. A directed sweep covers all operation codes
// and the addressing corner cases. Random traffic then runs under four
// idle/stall profiles on the request and byte sides.
// ----------------------------------------------------------------------------
module tb_x86_64_instruction_encoder_unit;
  import x86enc_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned MISMATCH_SHOWN = 10;
  // Worst-case drain: one 10-byte instruction plus pipeline slack
  localparam int unsigned DRAIN_CYCLES   = 2 * MAX_BYTES + 8;

  // Operation codes left unused by the encoder; they must produce no bytes
  localparam logic [4:0] OP_RSVD_LO = 5'd30;
  localparam logic [4:0] OP_RSVD_HI = 5'd31;

  // ModRM mod field
  localparam logic [1:0] MOD_IND    = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_DIRECT = 2'd3;

  // ModRM reg-field opcode extensions
  localparam logic [3:0] EXT_MOV  = 4'd0;
  localparam logic [3:0] EXT_ADD  = 4'd0;
  localparam logic [3:0] EXT_CALL = 4'd2;
  localparam logic [3:0] EXT_NEG  = 4'd3;
  localparam logic [3:0] EXT_SHL  = 4'd4;
  localparam logic [3:0] EXT_SUB  = 4'd5;
  localparam logic [3:0] EXT_SHR  = 4'd5;
  localparam logic [3:0] EXT_CMP  = 4'd7;
  localparam logic [3:0] EXT_SAR  = 4'd7;
  localparam logic [3:0] EXT_IDIV = 4'd7;

  // Low bits of the base register that need special addressing
  localparam logic [2:0] BASE_SIB   = 3'd4;  // rsp / r12
  localparam logic [2:0] BASE_NOIND = 3'd5;  // rbp / r13

  typedef struct packed {
    logic [4:0]  op;
    logic [3:0]  first;
    logic [3:0]  second;
    logic [63:0] imm;
    logic [31:0] disp;
    logic [7:0]  count;
    logic [3:0]  cc;
  } instr_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } code_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [4:0]  operation;
  logic [3:0]  first_reg;
  logic [3:0]  second_reg;
  logic [63:0] immediate;
  logic [31:0] displacement;
  logic [7:0]  small_count;
  logic [3:0]  cond_code;
  logic        empty;
  logic        pop;
  logic [7:0]  code_byte;
  logic        last_byte;

  // Expected machine code, oldest byte first
  code_t       pending_bytes[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  x86_64_instruction_encoder_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .first_reg    (first_reg),
    .second_reg   (second_reg),
    .immediate    (immediate),
    .displacement (displacement),
    .small_count  (small_count),
    .cond_code    (cond_code),
    .empty        (empty),
    .pop          (pop),
    .code_byte    (code_byte),
    .last_byte    (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Encoding predictor: appends the expected bytes of one instruction
  // --------------------------------------------------------------------------
  function automatic void emit_byte(input logic [7:0] value);
    pending_bytes.push_back('{value: value, last: 1'b0});
  endfunction

  // Little-endian 32-bit field
  function automatic void emit_dword(input logic [31:0] value);
    for (int k = 0; k < 4; k++) emit_byte(value[8*k +: 8]);
  endfunction

  function automatic logic [7:0] rex_w(input logic [3:0] regf, input logic [3:0] rmf);
    return BYTE_REX_W | {5'b0, regf[3], 1'b0, rmf[3]};
  endfunction

  // REX.W, opcode, register-direct ModRM
  function automatic void emit_reg_form(input logic [7:0] opc, input logic [3:0] regf,
                                        input logic [3:0] rmf);
    emit_byte(rex_w(regf, rmf));
    emit_byte(opc);
    emit_byte({MOD_DIRECT, regf[2:0], rmf[2:0]});
  endfunction

  // Base + displacement addressing. rbp/r13 has no plain indirect mode, so a
  // zero offset still needs a disp8; rsp/r12 always needs the SIB byte.
  function automatic void emit_mem_form(input logic [7:0] opc, input logic [3:0] regf,
                                        input logic [3:0] base, input logic [31:0] disp);
    logic [1:0] md;
    if (disp == 32'd0 && base[2:0] != BASE_NOIND) md = MOD_IND;
    else if ($signed(disp) >= -128 && $signed(disp) <= 127) md = MOD_DISP8;
    else md = MOD_DISP32;
    emit_byte(rex_w(regf, base));
    emit_byte(opc);
    emit_byte({md, regf[2:0], base[2:0]});
    if (base[2:0] == BASE_SIB) emit_byte(BYTE_SIB_RSP);
    if (md == MOD_DISP8) emit_byte(disp[7:0]);
    else if (md == MOD_DISP32) emit_dword(disp);
  endfunction

  function automatic void predict_encoding(input instr_t it);
    int unsigned start;
    start = pending_bytes.size();
    case (it.op)
      OP_MOV_IMM64: begin
        emit_byte(BYTE_REX_W | {7'b0, it.first[3]});
        emit_byte(BYTE_MOV_RI + {5'b0, it.first[2:0]});
        emit_dword(it.imm[31:0]);
        emit_dword(it.imm[63:32]);
      end
      OP_MOV_IMM32: begin
        emit_reg_form(BYTE_MOV_I, EXT_MOV, it.first);
        emit_dword(it.imm[31:0]);
      end
      OP_MOV_REG_REG: emit_reg_form(BYTE_MOV_ST, it.second, it.first);
      OP_LOAD:        emit_mem_form(BYTE_MOV_LD, it.first, it.second, it.disp);
      OP_STORE:       emit_mem_form(BYTE_MOV_ST, it.first, it.second, it.disp);
      OP_ADD_RR:      emit_reg_form(BYTE_ADD, it.second, it.first);
      OP_ADD_IMM32: begin
        emit_reg_form(BYTE_ALU_I, EXT_ADD, it.first);
        emit_dword(it.imm[31:0]);
      end
      OP_SUB_RR:      emit_reg_form(BYTE_SUB, it.second, it.first);
      OP_SUB_IMM32: begin
        emit_reg_form(BYTE_ALU_I, EXT_SUB, it.first);
        emit_dword(it.imm[31:0]);
      end
      OP_IMUL_RR: begin
        // Destination sits in the reg field here, unlike the other ALU forms
        emit_byte(rex_w(it.first, it.second));
        emit_byte(BYTE_ESC);
        emit_byte(BYTE_IMUL);
        emit_byte({MOD_DIRECT, it.first[2:0], it.second[2:0]});
      end
      OP_XOR_RR:      emit_reg_form(BYTE_XOR, it.second, it.first);
      OP_CMP_RR:      emit_reg_form(BYTE_CMP, it.second, it.first);
      OP_CMP_IMM32: begin
        emit_reg_form(BYTE_ALU_I, EXT_CMP, it.first);
        emit_dword(it.imm[31:0]);
      end
      OP_TEST_RR:     emit_reg_form(BYTE_TEST, it.second, it.first);
      OP_LEA:         emit_mem_form(BYTE_LEA, it.first, it.second, it.disp);
      OP_SHL_IMM8: begin
        emit_reg_form(BYTE_SHIFT_I, EXT_SHL, it.first);
        emit_byte(it.count);
      end
      OP_SHR_IMM8: begin
        emit_reg_form(BYTE_SHIFT_I, EXT_SHR, it.first);
        emit_byte(it.count);
      end
      OP_SAR_IMM8: begin
        emit_reg_form(BYTE_SHIFT_I, EXT_SAR, it.first);
        emit_byte(it.count);
      end
      OP_NEG:         emit_reg_form(BYTE_GRP3, EXT_NEG, it.first);
      OP_CQO: begin
        emit_byte(BYTE_REX_W);
        emit_byte(BYTE_CQO);
      end
      OP_IDIV:        emit_reg_form(BYTE_GRP3, EXT_IDIV, it.first);
      OP_RET:         emit_byte(BYTE_RET);
      OP_JMP_REL32: begin
        emit_byte(BYTE_JMP);
        emit_dword(32'd0);
      end
      OP_JCC_REL32: begin
        emit_byte(BYTE_ESC);
        emit_byte(BYTE_JCC | {4'b0, it.cc});
        emit_dword(32'd0);
      end
      OP_CALL_REL32: begin
        emit_byte(BYTE_CALL);
        emit_dword(32'd0);
      end
      OP_CALL_REG:    emit_reg_form(BYTE_GRP5, EXT_CALL, it.first);
      OP_PUSH: begin
        if (it.first[3]) emit_byte(BYTE_REX_B);
        emit_byte(BYTE_PUSH + {5'b0, it.first[2:0]});
      end
      OP_POP: begin
        if (it.first[3]) emit_byte(BYTE_REX_B);
        emit_byte(BYTE_POP + {5'b0, it.first[2:0]});
      end
      OP_SUB_RSP_IMM8: begin
        emit_byte(BYTE_REX_W);
        emit_byte(BYTE_ALU_I8);
        emit_byte(BYTE_RSP_SUB);
        emit_byte(it.count);
      end
      OP_ADD_RSP_IMM8: begin
        emit_byte(BYTE_REX_W);
        emit_byte(BYTE_ALU_I8);
        emit_byte(BYTE_RSP_ADD);
        emit_byte(it.count);
      end
      default: ;  // reserved codes encode to nothing
    endcase
    if (pending_bytes.size() > start) pending_bytes[$].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Sends one request; push stays high afterwards so back-to-back requests
  // never drop it. A random idle gap lowers it first.
  task automatic send_instr(input instr_t it);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    push         <= 1'b1;
    operation    <= it.op;
    first_reg    <= it.first;
    second_reg   <= it.second;
    immediate    <= it.imm;
    displacement <= it.disp;
    small_count  <= it.count;
    cond_code    <= it.cc;
    do @(posedge clk); while (full);
    predict_encoding(it);
  endtask

  function automatic logic [63:0] pick_extreme64(input logic [1:0] sel);
    case (sel)
      2'd0: return 64'h0000_0000_0000_0000;
      2'd1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2'd2: return 64'h8000_0000_0000_0000;
      default: return 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  // Every operation code once, reserved ones included, with the fields
  // walking through their extreme values
  task automatic test_every_operation();
    instr_t      it;
    logic [63:0] wide;
    for (int i = 0; i < 32; i++) begin
      wide      = pick_extreme64(2'(i + 1));
      it.op     = 5'(i);
      it.first  = 4'(i);
      it.second = ~4'(i);
      it.imm    = pick_extreme64(2'(i));
      it.disp   = wide[63:32];
      it.count  = i[0] ? 8'hFF : 8'h00;
      it.cc     = 4'(i);
      send_instr(it);
    end
  endtask

  // Addressing corners: no-index bases with zero offset, SIB bases, and
  // both edges of the disp8 range
  task automatic test_memory_modes();
    instr_t it;
    logic [3:0]  bases[8] = '{4'd5, 4'd13, 4'd4, 4'd12, 4'd0, 4'd8, 4'd12, 4'd5};
    logic [31:0] disps[8] = '{32'd0, 32'd0, 32'd0, 32'd127, 32'hFFFF_FF80,
                              32'd128, 32'hFFFF_FF7F, 32'hFFFF_FFFF};
    logic [4:0]  ops[3]   = '{OP_LOAD, OP_STORE, OP_LEA};
    for (int i = 0; i < 8; i++) begin
      it        = '0;
      it.op     = ops[i % 3];
      it.first  = 4'(15 - i);
      it.second = bases[i];
      it.disp   = disps[i];
      send_instr(it);
    end
  endtask

  function automatic logic [31:0] random_disp();
    logic [31:0] edges[4] = '{32'd127, 32'd128, 32'hFFFF_FF80, 32'hFFFF_FF7F};
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'($urandom_range(0, 255)) - 32'd128;
      2: return edges[$urandom_range(0, 3)];
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t random_instr();
    instr_t it;
    logic [3:0]  odd_bases[4] = '{4'd4, 4'd5, 4'd12, 4'd13};
    logic [4:0]  mem_ops[3]   = '{OP_LOAD, OP_STORE, OP_LEA};
    case ($urandom_range(0, 19))
      0:       it.op = $urandom_range(0, 1) ? OP_RSVD_LO : OP_RSVD_HI;
      1, 2, 3, 4, 5: it.op = mem_ops[$urandom_range(0, 2)];
      default: it.op = 5'($urandom_range(0, 29));
    endcase
    it.first  = 4'($urandom_range(0, 15));
    it.second = $urandom_range(0, 2) == 0 ? odd_bases[$urandom_range(0, 3)]
                                          : 4'($urandom_range(0, 15));
    it.imm    = $urandom_range(0, 7) == 0 ? pick_extreme64(2'($urandom_range(0, 3)))
                                          : {$urandom, $urandom};
    it.disp   = random_disp();
    it.count  = 8'($urandom_range(0, 255));
    it.cc     = 4'($urandom_range(0, 15));
    return it;
  endfunction

  task automatic test_random_traffic(input int unsigned n, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (n) send_instr(random_instr());
  endtask

  // --------------------------------------------------------------------------
  // Byte side: random pop pacing and the in-order check
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input code_t want, input logic [7:0] got,
                               input logic got_last);
    if (mismatch_count < MISMATCH_SHOWN)
      $display("[%0t] %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, want.value, want.last, got, got_last);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : byte_check
    code_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_bytes.size() == 0) begin
          note_mismatch("unexpected transaction", '0, code_byte, last_byte);
        end else begin
          want = pending_bytes.pop_front();
          if (code_byte !== want.value || last_byte !== want.last)
            note_mismatch("byte mismatch", want, code_byte, last_byte);
        end
      end
      pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    push               = 1'b0;
    pop                = 1'b0;
    operation          = '0;
    first_reg          = '0;
    second_reg         = '0;
    immediate          = '0;
    displacement       = '0;
    small_count        = '0;
    cond_code          = '0;
    mismatch_count     = 0;
    cycle_count        = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_every_operation();
    test_memory_modes();
    test_random_traffic(120, 0, 0);    // full rate both ways
    test_random_traffic(110, 69, 0);   // sparse requests
    test_random_traffic(110, 0, 69);   // slow consumer, queue backs up
    test_random_traffic(110, 14, 14);  // light jitter on both sides

    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    // Catch stray bytes that show up after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hdl/x86enc_pkg.sv
hdl/x86enc_front.sv
hdl/x86enc_queue.sv
hdl/x86enc_back.sv
hdl/x86_64_instruction_encoder_unit.sv
hdl/x86enc_checker.sv
tb/tb_x86_64_instruction_encoder_unit.sv
